// ----- rtl/core/xrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and field widths of the xoroshiro128+ generator.
// Used by every module under rtl/core; depends on nothing.
package xrs_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int OP_W    = 2;
    localparam int BOUND_W = 31;
    localparam int ADDR_W  = 4;

    // Splitmix64 constants.
    localparam logic [WORD_W-1:0] GAMMA   = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] MUL_ONE = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MUL_TWO = 64'h94D049BB133111EB;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // xoroshiro128+ step constants.
    localparam int ROT_A     = 55;
    localparam int ROT_B     = 36;
    localparam int SHIFT_A   = 14;
    localparam int FRAC_DROP = 12;

    // Restoring divider: one dividend bit per cycle.
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH_DEF = 4;

    // Operation codes; the unused code behaves as a raw draw.
    localparam logic [OP_W-1:0] OP_RAW  = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAC = 2'd1;
    localparam logic [OP_W-1:0] OP_MOD  = 2'd2;

    // Register index of the seed register.
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BOUND_W-1:0] bound;
        logic [WORD_W-1:0]  draw;
    } t_item;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_seed_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_st;

endpackage

// ----- rtl/core/xoroshiro128plus_generator.sv -----
`timescale 1ns / 1ps
// Top level of the xoroshiro128+ generator with splitmix64 seeding.
// Depends on xrs_pkg, xrs_seeder, xrs_front, xrs_queue and xrs_back.
//
// Request channel: i_valid, o_stall, i_op, i_bound. A transaction is taken
// at a clock edge with i_valid high and o_stall low. Result channel:
// o_valid, i_stall, o_value, one result per request, in request order.
// Op 0 (and the unused code 3) returns the raw draw, op 1 the draw shifted
// right by 12 (a Q0.52 fraction), op 2 the draw modulo i_bound (0 when the
// bound is 0).
// Raw and fraction requests stream at one per cycle while o_stall and
// i_stall stay low; each draw passes through the queue into the result
// register. A modulo request with a nonzero bound runs a bit-serial
// divider, one dividend bit per cycle, and holds the back end until it is
// done; the front end keeps drawing into a short queue meanwhile.
// After reset, and after every write of the seed register over the APB
// port, both state words are reseeded by a shared 32x32 multiplier
// sequence; o_stall stays high until both words are loaded.
// When i_stall holds the result register, the queue absorbs further
// requests until it is full, then o_stall rises.
module xoroshiro128plus_generator
    import xrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [BOUND_W-1:0] i_bound,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    logic [WORD_W-1:0] r_seed;
    logic              seed_wr;
    logic              seed_sel;
    t_seed_out         seed_out;
    t_queue_st         queue_st;
    t_item             push_item;
    t_item             head_item;
    logic              push;
    logic              pop;

    // Registers sit at 8-byte strides; the low three address bits are not decoded.
    assign seed_sel = (paddr[ADDR_W-1] == REG_SEED);
    assign pready   = 1'b1;
    assign seed_wr  = psel & penable & pwrite & pready & seed_sel;
    assign prdata   = seed_sel ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (seed_wr) begin
            r_seed <= pwdata;
        end
    end

    xrs_seeder u_seeder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seed_wr),
        .i_seed  (pwdata),
        .o_seed  (seed_out)
    );

    xrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_bound (i_bound),
        .i_seed  (seed_out),
        .i_queue (queue_st),
        .o_push  (push),
        .o_item  (push_item)
    );

    xrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (queue_st)
    );

    xrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_item),
        .i_queue (queue_st),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value)
    );

endmodule

// ----- rtl/core/xrs_seeder.sv -----
`timescale 1ns / 1ps
// Splitmix64 seeder: derives both state words from a seed value, with one
// shared 32x32 multiplier stepped by a small sequencer. Depends on xrs_pkg.
module xrs_seeder
    import xrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_seed,
    output t_seed_out         o_seed
);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_MIX0  = 4'd0;
    localparam logic [STEP_W-1:0] ST_P1_LL = 4'd1;
    localparam logic [STEP_W-1:0] ST_P1_LH = 4'd2;
    localparam logic [STEP_W-1:0] ST_P1_HL = 4'd3;
    localparam logic [STEP_W-1:0] ST_MIX1  = 4'd4;
    localparam logic [STEP_W-1:0] ST_P2_LL = 4'd5;
    localparam logic [STEP_W-1:0] ST_P2_LH = 4'd6;
    localparam logic [STEP_W-1:0] ST_P2_HL = 4'd7;
    localparam logic [STEP_W-1:0] ST_MIX2  = 4'd8;

    logic              r_busy;
    logic              r_done;
    logic              r_word;
    logic [STEP_W-1:0] r_step;
    logic [WORD_W-1:0] r_run;
    logic [WORD_W-1:0] r_z;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_word_a;
    logic [WORD_W-1:0] r_word_b;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] sum_t;
    logic [WORD_W-1:0] n_z;

    // The low 64 bits of z * C are lo*lo plus the low halves of both cross
    // products moved up by 32 bits; the high*high term falls off the top.
    always_comb begin
        mul_a = r_z[HALF_W-1:0];
        mul_b = MUL_ONE[HALF_W-1:0];
        case (r_step)
            ST_P1_LL: begin
                mul_b = MUL_ONE[HALF_W-1:0];
            end
            ST_P1_LH: begin
                mul_b = MUL_ONE[WORD_W-1:HALF_W];
            end
            ST_P1_HL: begin
                mul_a = r_z[WORD_W-1:HALF_W];
            end
            ST_P2_LL: begin
                mul_b = MUL_TWO[HALF_W-1:0];
            end
            ST_P2_LH: begin
                mul_b = MUL_TWO[WORD_W-1:HALF_W];
            end
            ST_P2_HL: begin
                mul_a = r_z[WORD_W-1:HALF_W];
                mul_b = MUL_TWO[HALF_W-1:0];
            end
            default: begin
                mul_a = r_z[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign sum_t = r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb begin
        case (r_step)
            ST_MIX0: begin
                n_z = r_run ^ (r_run >> MIX_SH0);
            end
            ST_MIX1: begin
                n_z = sum_t ^ (sum_t >> MIX_SH1);
            end
            default: begin
                n_z = sum_t ^ (sum_t >> MIX_SH2);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_word <= 1'b0;
            r_step <= ST_MIX0;
            r_run  <= GAMMA;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_word <= 1'b0;
                r_step <= ST_MIX0;
                r_run  <= i_seed + GAMMA;
            end else if (r_busy) begin
                if (r_step == ST_MIX2) begin
                    r_step <= ST_MIX0;
                    r_run  <= r_run + GAMMA;
                    r_word <= 1'b1;
                    if (r_word) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_prod <= mul_p;
            if (r_step == ST_P1_LH || r_step == ST_P2_LH) begin
                r_acc <= r_prod;
            end else if (r_step == ST_P1_HL || r_step == ST_P2_HL) begin
                r_acc <= sum_t;
            end
            if (r_step == ST_MIX0 || r_step == ST_MIX1) begin
                r_z <= n_z;
            end
            if (r_step == ST_MIX2) begin
                if (r_word) begin
                    r_word_b <= n_z;
                end else begin
                    r_word_a <= n_z;
                end
            end
        end
    end

    assign o_seed.busy   = r_busy | r_done;
    assign o_seed.done   = r_done;
    assign o_seed.word_a = r_word_a;
    assign o_seed.word_b = r_word_b;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("seeder done held longer than one cycle");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= ST_MIX2))
        else $error("seeder step out of range");

endmodule

// ----- rtl/core/xrs_front.sv -----
`timescale 1ns / 1ps
// Front end: holds the two state words, takes requests, advances the
// xoroshiro128+ state and queues each draw with its op. Depends on xrs_pkg.
module xrs_front
    import xrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [BOUND_W-1:0] i_bound,
    input  t_seed_out          i_seed,
    input  t_queue_st          i_queue,
    output logic               o_push,
    output t_item              o_item
);

    logic [WORD_W-1:0] r_word_a;
    logic [WORD_W-1:0] r_word_b;
    logic [WORD_W-1:0] mix_b;
    logic [WORD_W-1:0] n_word_a;
    logic [WORD_W-1:0] n_word_b;

    assign mix_b    = r_word_a ^ r_word_b;
    assign n_word_a = ((r_word_a << ROT_A) | (r_word_a >> (WORD_W - ROT_A)))
                      ^ mix_b ^ (mix_b << SHIFT_A);
    assign n_word_b = (mix_b << ROT_B) | (mix_b >> (WORD_W - ROT_B));

    assign o_stall = i_seed.busy | i_queue.full;
    assign o_push  = i_valid & ~o_stall;

    assign o_item.op    = i_op;
    assign o_item.bound = i_bound;
    assign o_item.draw  = r_word_a + r_word_b;

    always_ff @(posedge i_clk) begin
        if (i_seed.done) begin
            r_word_a <= i_seed.word_a;
            r_word_b <= i_seed.word_b;
        end else if (o_push) begin
            r_word_a <= n_word_a;
            r_word_b <= n_word_b;
        end
    end

    a_no_push_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seed.busy |-> !o_push)
        else $error("request taken while the state is being seeded");

endmodule

// ----- rtl/core/xrs_queue.sv -----
`timescale 1ns / 1ps
// Short queue of drawn items between the front and back ends.
// Depends on xrs_pkg.
module xrs_queue
    import xrs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_queue_st o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/core/xrs_back.sv -----
`timescale 1ns / 1ps
// Back end: formats each queued draw, runs the bit-serial remainder for
// the modulo op and drives the output register. Depends on xrs_pkg.
module xrs_back
    import xrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_head,
    input  t_queue_st         i_queue,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_value
);

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] BK_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] BK_DIV  = 2'd1;
    localparam logic [STATE_W-1:0] BK_HOLD = 2'd2;

    logic [STATE_W-1:0]   r_state;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_value;
    logic [WORD_W-1:0]    r_dvd;
    logic [BOUND_W-1:0]   r_rem;
    logic [BOUND_W-1:0]   r_bound;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic                 out_free;
    logic                 head_div;
    logic [WORD_W-1:0]    head_value;
    logic [BOUND_W:0]     trial;
    logic [BOUND_W:0]     diff;
    logic                 fits;
    logic [BOUND_W-1:0]   n_rem;
    logic                 load_direct;
    logic                 load_rem;

    assign out_free = ~r_out_valid | ~i_stall;
    assign head_div = (i_head.op == OP_MOD) && (i_head.bound != '0);

    always_comb begin
        case (i_head.op)
            OP_FRAC: begin
                head_value = i_head.draw >> FRAC_DROP;
            end
            OP_MOD: begin
                // Only reached with a zero bound, which yields zero.
                head_value = '0;
            end
            default: begin
                head_value = i_head.draw;
            end
        endcase
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The partial remainder stays below the bound, so it fits in 31 bits.
    assign trial = {r_rem, r_dvd[WORD_W-1]};
    assign diff  = trial - {1'b0, r_bound};
    assign fits  = (trial >= {1'b0, r_bound});
    assign n_rem = fits ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];

    assign o_pop = (r_state == BK_IDLE) && !i_queue.empty && (head_div || out_free);
    assign load_direct = o_pop && !head_div;
    assign load_rem    = (r_state == BK_HOLD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (load_direct || load_rem) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                BK_IDLE: begin
                    if (o_pop && head_div) begin
                        r_state <= BK_DIV;
                        r_cnt   <= '0;
                    end
                end
                BK_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= BK_HOLD;
                    end
                end
                BK_HOLD: begin
                    if (out_free) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && head_div) begin
            r_dvd   <= i_head.draw;
            r_rem   <= '0;
            r_bound <= i_head.bound;
        end else if (r_state == BK_DIV) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
        if (load_direct) begin
            r_out_value <= head_value;
        end else if (load_rem) begin
            r_out_value <= {{(WORD_W - BOUND_W){1'b0}}, r_rem};
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    a_rem_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV || r_state == BK_HOLD) |-> (r_rem < r_bound))
        else $error("partial remainder not below the bound");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV && $past(r_state) == BK_IDLE) |-> (r_cnt == '0))
        else $error("divider started with a stale step count");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |=> !(load_direct && $past(r_state) == BK_DIV
                                  && r_state == BK_DIV))
        else $error("item taken while the divider is busy");

endmodule

// ----- verif/xrs_draw_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard of the xoroshiro128+ generator testbench: an independent predictor
// of the splitmix64 seeding and the xoroshiro128+ draws. Depends on xrs_pkg.
package xrs_draw_check_pkg;

    import xrs_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_SEED   = 4'h0;
    // Byte address of register index 1, which does not exist.
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 4'h8;
    localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;

    class draw_scoreboard;

        logic [WORD_W-1:0] seed_reg;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] pending_values[$];
        int                errors;

        function new();
            seed_reg = '0;
            errors   = 0;
            reseed();
        endfunction

        function logic [WORD_W-1:0] splitmix_mix(logic [WORD_W-1:0] z);
            z = (z ^ (z >> MIX_SH0)) * MUL_ONE;
            z = (z ^ (z >> MIX_SH1)) * MUL_TWO;
            return z ^ (z >> MIX_SH2);
        endfunction

        function void reseed();
            logic [WORD_W-1:0] running;
            running = seed_reg + GAMMA;
            word_a  = splitmix_mix(running);
            running = running + GAMMA;
            word_b  = splitmix_mix(running);
        endfunction

        // A write to any address but the seed register changes nothing.
        function void write_register(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
            if (addr == ADDR_SEED) begin
                seed_reg = data;
                reseed();
            end
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [BOUND_W-1:0] bound);
            logic [WORD_W-1:0] draw;
            logic [WORD_W-1:0] mixed;
            logic [WORD_W-1:0] value;
            draw   = word_a + word_b;
            mixed  = word_b ^ word_a;
            word_a = ((word_a << ROT_A) | (word_a >> (WORD_W - ROT_A))) ^ mixed
                     ^ (mixed << SHIFT_A);
            word_b = (mixed << ROT_B) | (mixed >> (WORD_W - ROT_B));
            // The spare op code falls through to the raw draw; a zero bound yields 0.
            if (op == OP_FRAC) begin
                value = draw >> FRAC_DROP;
            end else if (op == OP_MOD) begin
                value = (bound != '0) ? (draw % WORD_W'(bound)) : '0;
            end else begin
                value = draw;
            end
            pending_values.push_back(value);
        endfunction

        function void check_value(logic [WORD_W-1:0] actual);
            logic [WORD_W-1:0] expected;
            if (pending_values.size() == 0) begin
                $error("o_value: no result expected, actual %h", actual);
                errors++;
            end else begin
                expected = pending_values.pop_front();
                if (actual !== expected) begin
                    $error("o_value mismatch: expected %h, actual %h", expected, actual);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_values.size();
        endfunction

    endclass

endpackage

// ----- verif/xoroshiro128plus_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of xoroshiro128plus_generator: directed and random
// requests under varying idle and stall rates, with seed writes between phases.
// Depends on xrs_pkg, xrs_draw_check_pkg and the generator RTL.
module xoroshiro128plus_generator_tb;

    import xrs_pkg::*;
    import xrs_draw_check_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 130;
    localparam logic [BOUND_W-1:0] BOUND_MAX = '1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [OP_W-1:0]    i_op;
    logic [BOUND_W-1:0] i_bound;
    logic               o_valid;
    logic               i_stall;
    logic [WORD_W-1:0]  o_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [WORD_W-1:0]  pwdata;
    logic [WORD_W-1:0]  prdata;
    logic               pready;

    int idle_pct;
    int stall_pct;
    int cycle_count;

    draw_scoreboard sb = new();

    xoroshiro128plus_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_bound (i_bound),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Requests are noted before results so a result never overtakes its request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.take_request(i_op, i_bound);
            end
            if (o_valid && !i_stall) begin
                sb.check_value(o_value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [BOUND_W-1:0] bound);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_bound <= bound;
        do @(posedge i_clk); while (o_stall);
    endtask

    // The count is first read after the next edge, once the last request has been noted.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_register(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            return OP_RAW;
        end else if (r < 55) begin
            return OP_FRAC;
        end else if (r < 90) begin
            return OP_MOD;
        end
        return OP_SPARE;
    endfunction

    function automatic logic [BOUND_W-1:0] pick_bound();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return BOUND_MAX;
        end else if (r <= 4) begin
            return BOUND_W'($urandom_range(1, 16));
        end
        return BOUND_W'($urandom());
    endfunction

    initial begin
        logic [WORD_W-1:0] seed_value;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = OP_RAW;
        i_bound     = '0;
        i_stall     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        cycle_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset seed: field extremes, every op, zero bound.
        send_request(OP_RAW, '0);
        send_request(OP_RAW, BOUND_MAX);
        send_request(OP_FRAC, '0);
        send_request(OP_FRAC, 31'h2AAAAAAA);
        send_request(OP_MOD, 31'd1);
        send_request(OP_MOD, BOUND_MAX);
        send_request(OP_MOD, '0);
        send_request(OP_MOD, 31'h55555555);
        send_request(OP_MOD, 31'h2AAAAAAA);
        send_request(OP_MOD, 31'd2);
        send_request(OP_SPARE, 31'h00001234);
        send_request(OP_MOD, 31'h40000000);
        drain_results();
        apb_write(ADDR_SEED, '1);
        send_request(OP_RAW, '0);
        send_request(OP_FRAC, '0);
        send_request(OP_MOD, 31'd7);
        send_request(OP_SPARE, BOUND_MAX);
        // A write to a register that does not exist must leave the sequence alone.
        drain_results();
        apb_write(ADDR_UNUSED, {$urandom(), $urandom()});
        send_request(OP_RAW, '0);
        send_request(OP_MOD, 31'd3);
        drain_results();
        apb_write(ADDR_SEED, 64'd1);
        send_request(OP_RAW, '0);
        send_request(OP_FRAC, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            if (phase == 2) begin
                seed_value = '0;
            end else if (phase == 5) begin
                seed_value = '1;
            end else begin
                seed_value = {$urandom(), $urandom()};
            end
            apb_write(ADDR_SEED, seed_value);
            case (phase % 4)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  <= 60;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 60;
                end
                default: begin
                    idle_pct  <= 17;
                    stall_pct <= 17;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_request(pick_op(), pick_bound());
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
